// File: rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants, codes and transaction types of the periodic task
// scheduler: command and record formats, table size and time width.
// ----------------------------------------------------------------------------
package pts_pkg;

  // table and time geometry
  localparam int SLOTS       = 8;
  localparam int TIME_BITS   = 32;
  localparam int MAX_RESULTS = 8;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TIME_W = TIME_BITS;
  localparam int CMP_W  = (TIME_BITS > 31) ? TIME_BITS : 31;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  // queue depths
  localparam int CQ_DEPTH = 2;
  localparam int RQ_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_REGISTER   = 2'd1,
    CMD_SET_ENABLE = 2'd2,
    CMD_RUN_NOW    = 2'd3
  } cmd_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PARAM = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    REC_FIRE   = 1'b0,
    REC_STATUS = 1'b1
  } rec_kind_t;

  // classified command, as queued between front and back
  typedef struct packed {
    cmd_op_t           op;
    logic [2:0]        sel_raw;
    logic [SLOT_W-1:0] sel;
    logic              sel_bad;
    logic [30:0]       ival;
    logic              ival_zero;
    logic              enable;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // one result record
  typedef struct packed {
    rec_kind_t  kind;
    logic [2:0] slot;
    status_t    status;
    logic       last;
  } rec_t;

endpackage

// File: rtl/pts_front.sv
// ----------------------------------------------------------------------------
// pts_front
// Command front end: accepts input transactions, classifies them and holds
// them in a short queue until the executor takes them.
// ----------------------------------------------------------------------------
module pts_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [1:0]    in_command,
  input  logic [2:0]    in_task_slot,
  input  logic [30:0]   in_interval_ms,
  input  logic          in_enable_flag,
  input  logic [31:0]   in_now_ms,
  output logic          full,
  output logic          q_valid,
  input  logic          q_pop,
  output pts_pkg::cmd_t q_data
);
  import pts_pkg::*;

  localparam int PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(CQ_DEPTH + 1);

  cmd_t              q_mem [CQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  cmd_t              cls;
  logic              do_push;
  logic              do_pop;

  // classify the incoming command
  always_comb begin
    cls.op        = cmd_op_t'(in_command);
    cls.sel_raw   = in_task_slot;
    cls.sel       = SLOT_W'(in_task_slot);
    cls.sel_bad   = (int'(in_task_slot) >= SLOTS);
    cls.ival      = in_interval_ms;
    cls.ival_zero = (in_interval_ms == '0);
    cls.enable    = in_enable_flag;
    cls.now       = TIME_W'(in_now_ms);
  end

  assign full    = (cnt_r == QCNT_W'(CQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = q_mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CQ_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CQ_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= QCNT_W'(cnt_r + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_r <= QCNT_W'(cnt_r - 1'b1);
      end
    end
  end

endmodule

// File: rtl/pts_res_q.sv
// ----------------------------------------------------------------------------
// pts_res_q
// Result queue: buffers records from the executor so that it can run on
// while the consumer stalls.
// ----------------------------------------------------------------------------
module pts_res_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rq_push,
  input  pts_pkg::rec_t rq_rec,
  output logic          rq_full,
  output logic          empty,
  input  logic          pop,
  output pts_pkg::rec_t head
);
  import pts_pkg::*;

  localparam int PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(RQ_DEPTH + 1);

  rec_t              r_mem [RQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign rq_full = (cnt_r == QCNT_W'(RQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = r_mem[rd_ptr_r];
  assign do_push = rq_push && !rq_full;
  assign do_pop  = pop && !empty;

  // record storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      r_mem[wr_ptr_r] <= rq_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(RQ_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(RQ_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= QCNT_W'(cnt_r + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_r <= QCNT_W'(cnt_r - 1'b1);
      end
    end
  end

endmodule

// File: rtl/pts_back.sv
// ----------------------------------------------------------------------------
// pts_back
// Executor: owns the slot table, scans it on a tick one slot per cycle unless
// a full result queue stalls it, and answers the register, set enable and run now commands.
// ----------------------------------------------------------------------------
module pts_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  pts_pkg::cmd_t q_data,
  output logic          rq_push,
  output pts_pkg::rec_t rq_rec,
  input  logic          rq_full
);
  import pts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_STAT,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0] pend_slot_r, pend_slot_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOTS-1:0]  en_r, en_nxt;

  // slot table storage and registered read
  logic [30:0]       slot_interval [SLOTS];
  logic [TIME_W-1:0] slot_last_fire [SLOTS];
  logic [30:0]       ival_q_r;
  logic [TIME_W-1:0] last_q_r;

  logic              we_reg;
  logic              we_last;
  logic [SLOT_W-1:0] free_idx;
  logic              tbl_full;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              scan_stall;
  logic              sel_hit;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign tbl_full   = &valid_r;
  assign elapsed    = cur_r.now - last_q_r;
  assign due        = valid_r[idx_r] && en_r[idx_r] &&
                      (CMP_W'(elapsed) >= CMP_W'(ival_q_r)) &&
                      (cnt_r < CNT_W'(MAX_RESULTS));
  assign scan_stall = due && pend_v_r && rq_full;
  assign sel_hit    = !cur_r.sel_bad && valid_r[cur_r.sel];

  // next-state and record generation
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    valid_nxt     = valid_r;
    en_nxt        = en_r;
    q_pop         = 1'b0;
    rq_push       = 1'b0;
    rq_rec.kind   = REC_STATUS;
    rq_rec.slot   = '0;
    rq_rec.status = ST_OK;
    rq_rec.last   = 1'b1;
    we_reg        = 1'b0;
    we_last       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_nxt    = q_data;
          idx_nxt    = '0;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = (q_data.op == CMD_TICK) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (!scan_stall) begin
          if (due) begin
            // the previous fire is now known not to be the last one
            if (pend_v_r) begin
              rq_push       = 1'b1;
              rq_rec.kind   = REC_FIRE;
              rq_rec.slot   = 3'(pend_slot_r);
              rq_rec.status = ST_OK;
              rq_rec.last   = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = idx_r;
            cnt_nxt       = CNT_W'(cnt_r + 1'b1);
            we_last       = 1'b1;
          end
          if (idx_r == SLOT_W'(SLOTS - 1)) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = SLOT_W'(idx_r + 1'b1);
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (!rq_full) begin
          rq_push       = 1'b1;
          rq_rec.kind   = REC_FIRE;
          rq_rec.slot   = 3'(pend_slot_r);
          rq_rec.status = ST_OK;
          rq_rec.last   = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_EXEC: begin
        if (!rq_full) begin
          rq_push   = 1'b1;
          state_nxt = S_IDLE;
          if (cur_r.op == CMD_REGISTER) begin
            priority if (cur_r.ival_zero) begin
              rq_rec.status = ST_BAD_PARAM;
            end else if (tbl_full) begin
              rq_rec.status = ST_FULL;
            end else begin
              rq_rec.slot         = 3'(free_idx);
              valid_nxt[free_idx] = 1'b1;
              en_nxt[free_idx]    = 1'b1;
              we_reg              = 1'b1;
            end
          end else if (!sel_hit) begin
            rq_rec.slot   = cur_r.sel_raw;
            rq_rec.status = ST_NOT_FOUND;
          end else if (cur_r.op == CMD_SET_ENABLE) begin
            rq_rec.slot       = cur_r.sel_raw;
            en_nxt[cur_r.sel] = cur_r.enable;
          end else begin
            // run now: fire record first, status follows
            rq_rec.kind = REC_FIRE;
            rq_rec.slot = cur_r.sel_raw;
            rq_rec.last = 1'b0;
            state_nxt   = S_STAT;
          end
        end
      end
      S_STAT: begin
        if (!rq_full) begin
          rq_push     = 1'b1;
          rq_rec.slot = cur_r.sel_raw;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      valid_r  <= '0;
      en_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      valid_r  <= valid_nxt;
      en_r     <= en_nxt;
    end
  end

  // command and pending fire payload
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    pend_slot_r <= pend_slot_nxt;
  end

  // slot table writes and read of the slot scanned next
  always_ff @(posedge clk) begin
    if (we_reg) begin
      slot_interval[free_idx]  <= cur_r.ival;
      slot_last_fire[free_idx] <= cur_r.now;
    end
    if (we_last) begin
      slot_last_fire[idx_r] <= cur_r.now;
    end
    ival_q_r <= slot_interval[idx_nxt];
    last_q_r <= slot_last_fire[idx_nxt];
  end

  // a stalled scan keeps its slot index
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_stall) |=> (idx_r == $past(idx_r)))
    else $error("scan index moved during a stall");

  // fire count stays within the per-tick limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("fire count beyond limit");

  // no pending fire survives into idle
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("pending fire left at end of tick");

  // records are only offered when the result queue has room
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> !rq_full)
    else $error("record pushed into full result queue");

  // a successful registration marks its slot valid and enabled
  a_reg_valid: assert property (@(posedge clk) disable iff (!rst_n)
    we_reg |=> (valid_r[$past(free_idx)] && en_r[$past(free_idx)]))
    else $error("registered slot not marked valid");

endmodule

// File: rtl/periodic_task_scheduler_unit.sv
// A command passes the command queue and the executor, and its records go into
// the result queue; run now puts out its fire record before its status record.
// A tick scans one slot a cycle, unless a full result queue stalls the scan.
// The executor takes a new command only when it has finished the last one, and
// it waits while the result queue is full and it has a record to put out.
// Reset: synchronous; valid and enable marks clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// periodic_task_scheduler_unit
// Top level of the periodic task scheduler: command front end, executor with
// the slot table, and result queue.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_task_slot,
  input  logic [30:0] in_interval_ms,
  input  logic        in_enable_flag,
  input  logic [31:0] in_now_ms,
  output logic        empty,
  input  logic        pop,
  output logic        out_record_kind,
  output logic [2:0]  out_slot,
  output logic [1:0]  out_status_code,
  output logic        out_last_of_run
);
  import pts_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_data;
  logic rq_push;
  rec_t rq_rec;
  logic rq_full;
  rec_t head;

  // front end and command queue
  pts_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .in_command     (in_command),
    .in_task_slot   (in_task_slot),
    .in_interval_ms (in_interval_ms),
    .in_enable_flag (in_enable_flag),
    .in_now_ms      (in_now_ms),
    .full           (full),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_data         (q_data)
  );

  // executor
  pts_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .rq_push (rq_push),
    .rq_rec  (rq_rec),
    .rq_full (rq_full)
  );

  // result queue
  pts_res_q u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .rq_push (rq_push),
    .rq_rec  (rq_rec),
    .rq_full (rq_full),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign out_record_kind = head.kind;
  assign out_slot        = head.slot;
  assign out_status_code = head.status;
  assign out_last_of_run = head.last;

endmodule
